// ===== rtl/assert_macros.svh =====
// Assertion helpers; clock and reset names follow the house convention.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, masked while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/cda_pkg.sv =====
package cda_pkg;

  localparam logic [13:0] YearMax  = 14'd9999;
  localparam logic [8:0]  Cycle400 = 9'd399;

  // divide by constant through reciprocal multiply
  localparam logic [15:0] Recip12  = 16'd43691;  // ceil(2^19 / 12)
  localparam logic [15:0] Recip400 = 16'd10486;  // ceil(2^22 / 400)
  localparam logic [16:0] Div12    = 17'd12;
  localparam logic [16:0] Div400   = 17'd400;

  typedef enum logic [1:0] {
    OP_SET    = 2'd0,
    OP_DAYS   = 2'd1,
    OP_MONTHS = 2'd2,
    OP_YEARS  = 2'd3
  } op_e;

  typedef enum logic {
    DIV_12  = 1'b0,
    DIV_400 = 1'b1
  } div_sel_e;

  typedef struct packed {
    logic [12:0] quot;
    logic [8:0]  rem;
  } cdiv_res_t;

  localparam logic [4:0] MonthLen [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  function automatic logic [4:0] days_in_month(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    len = 5'd31;
    if (month == 4'd2) begin
      len = leap ? 5'd29 : 5'd28;
    end else if (month >= 4'd1 && month <= 4'd12) begin
      len = MonthLen[month - 4'd1];
    end
    return len;
  endfunction

  // leap flag from year mod 400
  function automatic logic leap_of(input logic [8:0] y400);
    return (y400[1:0] == 2'd0) && (y400 != 9'd100) && (y400 != 9'd200) &&
           (y400 != 9'd300);
  endfunction

endpackage

// ===== rtl/cda_in_if.sv =====
interface cda_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [13:0] new_year;
  logic [3:0]  new_month;
  logic [4:0]  new_day;
  logic [15:0] amount;

  modport source (output valid, op, new_year, new_month, new_day, amount, input ready);
  modport sink   (input valid, op, new_year, new_month, new_day, amount, output ready);
endinterface

// ===== rtl/cda_out_if.sv =====
interface cda_out_if;
  logic        valid;
  logic        ready;
  logic [13:0] cur_year;
  logic [3:0]  cur_month;
  logic [4:0]  cur_day;
  logic        year_overflow;

  modport source (output valid, cur_year, cur_month, cur_day, year_overflow, input ready);
  modport sink   (input valid, cur_year, cur_month, cur_day, year_overflow, output ready);
endinterface

// ===== rtl/cda_cdiv.sv =====
`include "assert_macros.svh"

// Shared constant divider: operand and product registered on start,
// quotient and remainder valid the cycle after.
module cda_cdiv (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [16:0]          a_i,
  input  cda_pkg::div_sel_e    sel_i,
  output cda_pkg::cdiv_res_t   res_o
);

  logic [16:0]       a_q;
  cda_pkg::div_sel_e sel_q;
  logic [32:0]       prod_q;
  logic [15:0]       recip;
  logic [12:0]       quot;
  logic [16:0]       back12, back400, rem_full;

  assign recip = (sel_i == cda_pkg::DIV_12) ? cda_pkg::Recip12 : cda_pkg::Recip400;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q    <= a_i;
      sel_q  <= sel_i;
      prod_q <= 33'(a_i) * 33'(recip);
    end
  end

  always_comb begin
    if (sel_q == cda_pkg::DIV_12) begin
      quot = prod_q[31:19];
    end else begin
      quot = {8'd0, prod_q[26:22]};
    end
  end

  assign back12   = 17'(quot) * cda_pkg::Div12;
  assign back400  = 17'(quot) * cda_pkg::Div400;
  assign rem_full = a_q - ((sel_q == cda_pkg::DIV_12) ? back12 : back400);

  assign res_o.quot = quot;
  assign res_o.rem  = rem_full[8:0];

  `ASSERT_CLK(a_rem12, $past(start_i) && sel_q == cda_pkg::DIV_12 |-> rem_full < cda_pkg::Div12, "mod 12 remainder out of range")
  `ASSERT_CLK(a_rem400, $past(start_i) && sel_q == cda_pkg::DIV_400 |-> rem_full < cda_pkg::Div400, "mod 400 remainder out of range")

endmodule

// ===== rtl/calendar_date_adder_top.sv =====
// Channel   Dir  Fields                                          Beat when
// in_ch_i   in   op, new_year, new_month, new_day, amount        valid && ready
// out_ch_o  out  cur_year, cur_month, cur_day, year_overflow     valid && ready
//
// Set date and add years go from idle straight to done. Add months: one
// multiply through the shared constant divider, then the /12 fixup.
// Add days: year mod 400 comes from the divider first, then the date is
// walked forward month by month until the remaining days fit.
// Reset: date 2020-01-15, no result pending. in_ch_i.ready is high only in
// idle; a finished result waits in the output register while the next item
// is taken, and done stalls only while that register is full.
`include "assert_macros.svh"

module calendar_date_adder_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  cda_in_if.sink          in_ch_i,
  cda_out_if.source       out_ch_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MDIV = 6'b000010,
    S_YDIV = 6'b000100,
    S_WALK = 6'b001000,
    S_DONE = 6'b010000,
    S_SPAR = 6'b100000
  } state_e;

  state_e      state_q, state_d;
  logic [13:0] year_q, year_d;
  logic [3:0]  month_q, month_d;
  logic [4:0]  day_q, day_d;
  logic [8:0]  y400_q, y400_d;      // year mod 400 during a day walk
  logic [15:0] rem_q, rem_d;        // days still to add
  logic        ovf_q, ovf_d;

  logic        out_valid_q, out_valid_d;
  logic [13:0] out_year_q;
  logic [3:0]  out_month_q;
  logic [4:0]  out_day_q;
  logic        out_ovf_q;
  logic        out_load;

  logic               div_start;
  logic [16:0]        div_a;
  cda_pkg::div_sel_e  div_sel;
  cda_pkg::cdiv_res_t div_res;

  logic        accept;
  logic [16:0] sum_y;
  logic [16:0] mon_sum;
  logic [4:0]  md;
  logic [16:0] day_sum;
  logic [4:0]  used;

  cda_cdiv u_cdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .a_i     (div_a),
    .sel_i   (div_sel),
    .res_o   (div_res)
  );

  assign accept        = in_ch_i.valid && in_ch_i.ready;
  assign in_ch_i.ready = (state_q == S_IDLE);

  // shared adder input: years to add on add-years, quotient on add-months
  assign sum_y   = 17'(year_q) + ((state_q == S_MDIV) ? 17'(div_res.quot)
                                                       : 17'(in_ch_i.amount));
  assign mon_sum = 17'(month_q) - 17'd1 + 17'(in_ch_i.amount);

  assign md      = cda_pkg::days_in_month(month_q, cda_pkg::leap_of(y400_q));
  assign day_sum = 17'(day_q) + 17'(rem_q);
  assign used    = (day_q <= md) ? (md - day_q + 5'd1) : 5'd1;

  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ch_o.ready);

  always_comb begin
    state_d   = state_q;
    year_d    = year_q;
    month_d   = month_q;
    day_d     = day_q;
    y400_d    = y400_q;
    rem_d     = rem_q;
    ovf_d     = ovf_q;
    div_start = 1'b0;
    div_a     = mon_sum;
    div_sel   = cda_pkg::DIV_12;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          ovf_d = 1'b0;
          rem_d = in_ch_i.amount;
          unique case (cda_pkg::op_e'(in_ch_i.op))
            cda_pkg::OP_SET: begin
              if (in_ch_i.new_year > cda_pkg::YearMax) begin
                year_d = cda_pkg::YearMax;
                ovf_d  = 1'b1;
              end else begin
                year_d = in_ch_i.new_year;
              end
              if (in_ch_i.new_month == 4'd0) begin
                month_d = 4'd1;
              end else if (in_ch_i.new_month > 4'd12) begin
                month_d = 4'd12;
              end else begin
                month_d = in_ch_i.new_month;
              end
              day_d   = (in_ch_i.new_day == 5'd0) ? 5'd1 : in_ch_i.new_day;
              state_d = S_DONE;
            end
            cda_pkg::OP_DAYS: begin
              div_start = 1'b1;
              div_a     = 17'(year_q);
              div_sel   = cda_pkg::DIV_400;
              state_d   = S_YDIV;
            end
            cda_pkg::OP_MONTHS: begin
              div_start = 1'b1;
              state_d   = S_MDIV;
            end
            cda_pkg::OP_YEARS: begin
              if (sum_y > 17'(cda_pkg::YearMax)) begin
                year_d = cda_pkg::YearMax;
                ovf_d  = 1'b1;
              end else begin
                year_d = sum_y[13:0];
              end
              state_d = S_DONE;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_MDIV: begin
        if (sum_y > 17'(cda_pkg::YearMax)) begin
          year_d = cda_pkg::YearMax;
          ovf_d  = 1'b1;
        end else begin
          year_d = sum_y[13:0];
        end
        month_d = div_res.rem[3:0] + 4'd1;
        state_d = S_DONE;
      end
      S_YDIV: begin
        y400_d  = div_res.rem;
        state_d = S_WALK;
      end
      S_WALK: begin
        if (rem_q == 16'd0 || day_sum <= 17'(md)) begin
          day_d   = day_q + rem_q[4:0];
          state_d = S_DONE;
        end else begin
          rem_d = rem_q - 16'(used);
          day_d = 5'd1;
          if (month_q == 4'd12) begin
            month_d = 4'd1;
            if (year_q == cda_pkg::YearMax) begin
              ovf_d = 1'b1;
            end else begin
              year_d = year_q + 14'd1;
              y400_d = (y400_q == cda_pkg::Cycle400) ? 9'd0 : y400_q + 9'd1;
            end
          end else begin
            month_d = month_q + 4'd1;
          end
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ch_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      year_q      <= 14'd2020;
      month_q     <= 4'd1;
      day_q       <= 5'd15;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      year_q      <= year_d;
      month_q     <= month_d;
      day_q       <= day_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    y400_q <= y400_d;
    rem_q  <= rem_d;
    ovf_q  <= ovf_d;
    if (out_load) begin
      out_year_q  <= year_q;
      out_month_q <= month_q;
      out_day_q   <= day_q;
      out_ovf_q   <= ovf_q;
    end
  end

  assign out_ch_o.valid         = out_valid_q;
  assign out_ch_o.cur_year      = out_year_q;
  assign out_ch_o.cur_month     = out_month_q;
  assign out_ch_o.cur_day       = out_day_q;
  assign out_ch_o.year_overflow = out_ovf_q;

  `ASSERT_CLK(a_month_range, month_q >= 4'd1 && month_q <= 4'd12, "month register out of range")
  `ASSERT_CLK(a_year_range, year_q <= cda_pkg::YearMax, "year register above saturation limit")
  `ASSERT_CLK(a_out_from_done, $rose(out_valid_q) |-> $past(state_q == S_DONE), "result raised outside done")
  `ASSERT_CLK(a_done_needs_room, state_q == S_DONE && out_valid_q && !out_ch_o.ready |=> state_q == S_DONE, "pending result overwritten")

endmodule
